>>> src/rtbl_pkg.sv
// Shared types, constants and codes for the distance-vector route table.
package rtbl_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int MAX_RESULTS = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int RES_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [4:0] METRIC_INF = 5'd16;

    typedef enum logic [2:0] {
        OP_LOOKUP = 3'd0,
        OP_UPDATE = 3'd1,
        OP_POISON = 3'd2,
        OP_DIRECT = 3'd3,
        OP_ADVERT = 3'd4
    } op_t;

    typedef enum logic [3:0] {
        KIND_FORWARD     = 4'd0,
        KIND_DIRECT      = 4'd1,
        KIND_UNREACHABLE = 4'd2,
        KIND_SAME_HOP    = 4'd3,
        KIND_BETTER      = 4'd4,
        KIND_UNCHANGED   = 4'd5,
        KIND_ADDED       = 4'd6,
        KIND_FULL        = 4'd7,
        KIND_POISONED    = 4'd8,
        KIND_ADV_ENTRY   = 4'd9,
        KIND_ADV_EMPTY   = 4'd10
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [31:0] network;
        logic [31:0] mask;
        logic [15:0] next_hop;
        logic [4:0]  metric;
    } entry_t;

    typedef struct packed {
        logic [IDX_W-1:0] addr;
        logic             all_en;
        logic             hop_en;
        logic             metric_en;
        entry_t           data;
    } store_wr_t;

    typedef struct packed {
        logic prefix_hit;
        logic net_eq;
        logic hop_eq;
        logic better;
    } unit_flags_t;

endpackage

>>> src/distance_vector_route_table.sv
// Distance-vector route table top level: sequencer, item latch and result register.
// An item scans the stored entries one per cycle, stopping early on a lookup or update
// match and holding while an advert entry waits on the output, then goes to ST_FINISH;
// add direct network skips the scan. Items are taken one at a time, and the scan runs
// through the entry store's single read port; an output stall holds the finish.
// Reset: aresetn low clears the entry count (table empty) and the handshake state.
module distance_vector_route_table (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [31:0] address, [63:32] netmask, [68:64] metric_in, [84:69] neighbor_port
    input  logic [87:0] s_axis_tdata,
    // [2:0] op
    input  logic [2:0]  s_axis_tuser,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] next_hop, [47:16] out_network, [79:48] out_mask, [84:80] out_metric
    output logic [87:0] m_axis_tdata,
    // [3:0] kind
    output logic [3:0]  m_axis_tuser,
    output logic        m_axis_tlast
);

    localparam int IDX_W = rtbl_pkg::IDX_W;
    localparam int CNT_W = rtbl_pkg::CNT_W;
    localparam int RES_W = rtbl_pkg::RES_W;

    // Control state
    rtbl_pkg::state_t   state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [RES_W-1:0]   k_reg, k_next;
    logic               found_reg, found_next;
    logic               m_valid_reg, m_valid_next;

    // Latched item
    rtbl_pkg::op_t      op_reg, op_next;
    logic [31:0]        addr_reg, addr_next;
    logic [31:0]        nmask_reg, nmask_next;
    logic [4:0]         min_reg, min_next;
    logic [15:0]        nbr_reg, nbr_next;

    // Captured entry (lookup match, update candidate or pending advert entry)
    rtbl_pkg::entry_t   res_reg, res_next;
    logic               same_reg, same_next;
    logic               better_reg, better_next;

    // Result register
    rtbl_pkg::kind_t    m_kind_reg, m_kind_next;
    rtbl_pkg::entry_t   m_ent_reg, m_ent_next;
    logic               m_last_reg, m_last_next;

    rtbl_pkg::entry_t      rd_data;
    rtbl_pkg::store_wr_t   wr;
    rtbl_pkg::unit_flags_t flags;
    logic [4:0]            new_metric;

    logic s_fire;
    logic out_free;
    logic scan_last;
    logic scan_hit;
    logic adv_qual;
    logic scan_stall;
    logic table_full;

    rtbl_store u_store (
        .aclk    (aclk),
        .wr      (wr),
        .rd_addr (idx_next),
        .rd_data (rd_data)
    );

    rtbl_unit u_unit (
        .entry         (rd_data),
        .address       (addr_reg),
        .neighbor_port (nbr_reg),
        .metric_in     (min_reg),
        .new_metric    (new_metric),
        .flags         (flags)
    );

    assign s_axis_tready = (state_reg == rtbl_pkg::ST_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    // the result register can take a new transaction when empty or being drained
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign table_full    = (count_reg == CNT_W'(rtbl_pkg::TABLE_DEPTH));

    // Scan decisions for the entry presented by the store this cycle
    always_comb begin
        scan_last  = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
        adv_qual   = !flags.hop_eq && (k_reg < RES_W'(rtbl_pkg::MAX_RESULTS));
        scan_hit   = 1'b0;
        scan_stall = 1'b0;
        case (op_reg)
            rtbl_pkg::OP_LOOKUP: scan_hit   = flags.prefix_hit;
            rtbl_pkg::OP_UPDATE: scan_hit   = flags.net_eq;
            rtbl_pkg::OP_ADVERT: scan_stall = adv_qual && found_reg && !out_free;
            default: begin
                scan_hit   = 1'b0;
                scan_stall = 1'b0;
            end
        endcase
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rtbl_pkg::ST_IDLE: begin
                if (s_fire) begin
                    case (rtbl_pkg::op_t'(s_axis_tuser))
                        rtbl_pkg::OP_LOOKUP,
                        rtbl_pkg::OP_UPDATE,
                        rtbl_pkg::OP_POISON,
                        rtbl_pkg::OP_ADVERT: begin
                            state_next = (count_reg == '0) ? rtbl_pkg::ST_FINISH
                                                           : rtbl_pkg::ST_SCAN;
                        end
                        rtbl_pkg::OP_DIRECT: state_next = rtbl_pkg::ST_FINISH;
                        default:             state_next = rtbl_pkg::ST_IDLE;
                    endcase
                end
            end
            rtbl_pkg::ST_SCAN: begin
                if (scan_hit || (scan_last && !scan_stall)) begin
                    state_next = rtbl_pkg::ST_FINISH;
                end
            end
            rtbl_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = rtbl_pkg::ST_IDLE;
                end
            end
            default: state_next = rtbl_pkg::ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        idx_next    = idx_reg;
        count_next  = count_reg;
        k_next      = k_reg;
        found_next  = found_reg;
        op_next     = op_reg;
        addr_next   = addr_reg;
        nmask_next  = nmask_reg;
        min_next    = min_reg;
        nbr_next    = nbr_reg;
        res_next    = res_reg;
        same_next   = same_reg;
        better_next = better_reg;
        m_kind_next = m_kind_reg;
        m_ent_next  = m_ent_reg;
        m_last_next = m_last_reg;
        m_valid_next = m_axis_tready ? 1'b0 : m_valid_reg;
        wr          = '0;

        case (state_reg)
            rtbl_pkg::ST_IDLE: begin
                // keep slot 0 presented so a scan starts on fresh data
                idx_next = '0;
                if (s_fire) begin
                    op_next    = rtbl_pkg::op_t'(s_axis_tuser);
                    addr_next  = s_axis_tdata[31:0];
                    nmask_next = s_axis_tdata[63:32];
                    min_next   = s_axis_tdata[68:64];
                    nbr_next   = s_axis_tdata[84:69];
                    found_next = 1'b0;
                    k_next     = '0;
                end
            end

            rtbl_pkg::ST_SCAN: begin
                case (op_reg)
                    rtbl_pkg::OP_LOOKUP,
                    rtbl_pkg::OP_UPDATE: begin
                        // capture the matching entry and hold the index on it
                        if (scan_hit) begin
                            res_next    = rd_data;
                            found_next  = 1'b1;
                            same_next   = flags.hop_eq;
                            better_next = flags.better;
                        end
                    end
                    rtbl_pkg::OP_POISON: begin
                        if (flags.hop_eq) begin
                            wr.addr        = idx_reg;
                            wr.metric_en   = 1'b1;
                            wr.data.metric = rtbl_pkg::METRIC_INF;
                        end
                    end
                    rtbl_pkg::OP_ADVERT: begin
                        // emit the previous qualifying entry once a later one shows
                        // it is not the final transaction
                        if (adv_qual && !scan_stall) begin
                            if (found_reg) begin
                                m_valid_next = 1'b1;
                                m_kind_next  = rtbl_pkg::KIND_ADV_ENTRY;
                                m_ent_next   = res_reg;
                                m_last_next  = 1'b0;
                            end
                            res_next   = rd_data;
                            found_next = 1'b1;
                            k_next     = k_reg + RES_W'(1);
                        end
                    end
                    default: ;
                endcase
                if (!scan_hit && !scan_stall && !scan_last) begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            rtbl_pkg::ST_FINISH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_last_next  = 1'b1;
                    case (op_reg)
                        rtbl_pkg::OP_LOOKUP: begin
                            if (found_reg) begin
                                m_kind_next = (res_reg.next_hop == '0)
                                              ? rtbl_pkg::KIND_DIRECT
                                              : rtbl_pkg::KIND_FORWARD;
                                m_ent_next  = res_reg;
                            end else begin
                                m_kind_next         = rtbl_pkg::KIND_UNREACHABLE;
                                m_ent_next.network  = addr_reg;
                                m_ent_next.mask     = '0;
                                m_ent_next.next_hop = '0;
                                m_ent_next.metric   = rtbl_pkg::METRIC_INF;
                            end
                        end
                        rtbl_pkg::OP_UPDATE,
                        rtbl_pkg::OP_DIRECT: begin
                            if ((op_reg == rtbl_pkg::OP_UPDATE) && found_reg) begin
                                m_ent_next = res_reg;
                                wr.addr    = idx_reg;
                                if (same_reg) begin
                                    m_kind_next       = rtbl_pkg::KIND_SAME_HOP;
                                    m_ent_next.metric = new_metric;
                                    wr.metric_en      = 1'b1;
                                    wr.data.metric    = new_metric;
                                end else if (better_reg) begin
                                    m_kind_next         = rtbl_pkg::KIND_BETTER;
                                    m_ent_next.metric   = new_metric;
                                    m_ent_next.next_hop = nbr_reg;
                                    wr.metric_en        = 1'b1;
                                    wr.hop_en           = 1'b1;
                                    wr.data.metric      = new_metric;
                                    wr.data.next_hop    = nbr_reg;
                                end else begin
                                    m_kind_next = rtbl_pkg::KIND_UNCHANGED;
                                end
                            end else begin
                                // append at the fill point, or flag a full table
                                m_ent_next.network  = addr_reg;
                                m_ent_next.mask     = nmask_reg;
                                m_ent_next.next_hop = (op_reg == rtbl_pkg::OP_DIRECT)
                                                      ? 16'd0 : nbr_reg;
                                m_ent_next.metric   = (op_reg == rtbl_pkg::OP_DIRECT)
                                                      ? 5'd0 : new_metric;
                                if (table_full) begin
                                    m_kind_next = rtbl_pkg::KIND_FULL;
                                end else begin
                                    m_kind_next = rtbl_pkg::KIND_ADDED;
                                    wr.addr     = count_reg[IDX_W-1:0];
                                    wr.all_en   = 1'b1;
                                    wr.data     = m_ent_next;
                                    count_next  = count_reg + CNT_W'(1);
                                end
                            end
                        end
                        rtbl_pkg::OP_POISON: begin
                            m_kind_next         = rtbl_pkg::KIND_POISONED;
                            m_ent_next.network  = '0;
                            m_ent_next.mask     = '0;
                            m_ent_next.next_hop = nbr_reg;
                            m_ent_next.metric   = rtbl_pkg::METRIC_INF;
                        end
                        rtbl_pkg::OP_ADVERT: begin
                            if (found_reg) begin
                                m_kind_next = rtbl_pkg::KIND_ADV_ENTRY;
                                m_ent_next  = res_reg;
                            end else begin
                                m_kind_next = rtbl_pkg::KIND_ADV_EMPTY;
                                m_ent_next  = '0;
                            end
                        end
                        default: m_valid_next = m_axis_tready ? 1'b0 : m_valid_reg;
                    endcase
                end
            end

            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rtbl_pkg::ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
            k_reg       <= '0;
            found_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            idx_reg     <= idx_next;
            k_reg       <= k_next;
            found_reg   <= found_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        addr_reg   <= addr_next;
        nmask_reg  <= nmask_next;
        min_reg    <= min_next;
        nbr_reg    <= nbr_next;
        res_reg    <= res_next;
        same_reg   <= same_next;
        better_reg <= better_next;
        m_kind_reg <= m_kind_next;
        m_ent_reg  <= m_ent_next;
        m_last_reg <= m_last_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_kind_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tdata  = {3'b000, m_ent_reg.metric, m_ent_reg.mask,
                            m_ent_reg.network, m_ent_reg.next_hop};

endmodule

>>> src/rtbl_store.sv
// Route entry storage: one write port, one registered read port.
module rtbl_store (
    input  logic                      aclk,
    input  rtbl_pkg::store_wr_t       wr,
    input  logic [rtbl_pkg::IDX_W-1:0] rd_addr,
    output rtbl_pkg::entry_t          rd_data
);

    logic [31:0] net_mem    [rtbl_pkg::TABLE_DEPTH];
    logic [31:0] mask_mem   [rtbl_pkg::TABLE_DEPTH];
    logic [15:0] hop_mem    [rtbl_pkg::TABLE_DEPTH];
    logic [4:0]  metric_mem [rtbl_pkg::TABLE_DEPTH];

    rtbl_pkg::entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.all_en) begin
            net_mem[wr.addr]  <= wr.data.network;
            mask_mem[wr.addr] <= wr.data.mask;
        end
        if (wr.all_en || wr.hop_en) begin
            hop_mem[wr.addr] <= wr.data.next_hop;
        end
        if (wr.all_en || wr.metric_en) begin
            metric_mem[wr.addr] <= wr.data.metric;
        end
        rd_data_reg.network  <= net_mem[rd_addr];
        rd_data_reg.mask     <= mask_mem[rd_addr];
        rd_data_reg.next_hop <= hop_mem[rd_addr];
        rd_data_reg.metric   <= metric_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/rtbl_unit.sv
// Shared compare unit: checks one table entry against the current item.
module rtbl_unit (
    input  rtbl_pkg::entry_t      entry,
    input  logic [31:0]           address,
    input  logic [15:0]           neighbor_port,
    input  logic [4:0]            metric_in,
    output logic [4:0]            new_metric,
    output rtbl_pkg::unit_flags_t flags
);

    // saturate the advertised hop count plus one at infinity
    assign new_metric = (metric_in >= rtbl_pkg::METRIC_INF) ? rtbl_pkg::METRIC_INF
                                                            : metric_in + 5'd1;

    always_comb begin
        flags.prefix_hit = (entry.metric < rtbl_pkg::METRIC_INF) &&
                           ((address & entry.mask) == entry.network);
        flags.net_eq     = (entry.network == address);
        flags.hop_eq     = (entry.next_hop == neighbor_port);
        flags.better     = (entry.metric > new_metric);
    end

endmodule
